// ===== rtl/cau_pkg.sv =====
// Shared types and constants for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

  localparam int DW = 16;
  localparam int QB = 17;
  localparam int RW = 51;
  localparam int PW = 32;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic          is_div;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic [DW-1:0] re;
    logic [DW-1:0] im;
    logic [1:0]    status;
  } cau_side_t;

endpackage
`default_nettype wire

// ===== rtl/cau_front.sv =====
// Operand, product and sum stages: direct results and divider operands.
`default_nettype none
module cau_front
  import cau_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           in_kind,
  input  wire logic signed [DW-1:0] in_a_re,
  input  wire logic signed [DW-1:0] in_a_im,
  input  wire logic signed [DW-1:0] in_b_re,
  input  wire logic signed [DW-1:0] in_b_im,
  output logic                      fr_valid,
  output cau_side_t                 fr_side,
  output logic [RW-1:0]             fr_n_re,
  output logic [RW-1:0]             fr_n_im,
  output logic [RW-1:0]             fr_d
);

  logic                 v1_r, v2_r, v3_r;
  logic [1:0]           kind1_r, kind2_r;
  logic signed [DW-1:0] ar_r, ai_r, br_r, bi_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, sq_r_r, sq_i_r;
  logic signed [DW:0]   s_re_r, s_im_r;
  cau_side_t            side3_r, side_nxt;
  logic [RW-1:0]        n_re_r, n_im_r, d_r, n_re_nxt, n_im_nxt, d_nxt;

  logic signed [PW+1:0] mre, mim, rre, rim;
  logic signed [PW:0]   num_re, num_im;
  logic [PW-1:0]        den, mag_re, mag_im;
  logic                 sat_re, sat_im;
  logic [DW-1:0]        res_re, res_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind1_r <= in_kind;
      ar_r    <= in_a_re;
      ai_r    <= in_a_im;
      br_r    <= in_b_re;
      bi_r    <= in_b_im;
      kind2_r <= kind1_r;
      p_rr_r  <= ar_r * br_r;
      p_ii_r  <= ai_r * bi_r;
      p_ri_r  <= ar_r * bi_r;
      p_ir_r  <= ai_r * br_r;
      sq_r_r  <= br_r * br_r;
      sq_i_r  <= bi_r * bi_r;
      if (kind1_r == KIND_SUB) begin
        s_re_r <= (DW+1)'(ar_r) - (DW+1)'(br_r);
        s_im_r <= (DW+1)'(ai_r) - (DW+1)'(bi_r);
      end else begin
        s_re_r <= (DW+1)'(ar_r) + (DW+1)'(br_r);
        s_im_r <= (DW+1)'(ai_r) + (DW+1)'(bi_r);
      end
      side3_r <= side_nxt;
      n_re_r  <= n_re_nxt;
      n_im_r  <= n_im_nxt;
      d_r     <= d_nxt;
    end
  end

  always_comb begin
    mre    = (PW+2)'(p_rr_r) - (PW+2)'(p_ii_r);
    mim    = (PW+2)'(p_ri_r) + (PW+2)'(p_ir_r);
    num_re = (PW+1)'(p_rr_r) + (PW+1)'(p_ii_r);
    num_im = (PW+1)'(p_ir_r) - (PW+1)'(p_ri_r);
    den    = PW'(sq_r_r) + PW'(sq_i_r);
    mag_re = num_re[PW] ? PW'(-num_re) : num_re[PW-1:0];
    mag_im = num_im[PW] ? PW'(-num_im) : num_im[PW-1:0];
    if (kind2_r == KIND_MUL) begin
      rre = (mre + (PW+2)'(128)) >>> 8;
      rim = (mim + (PW+2)'(128)) >>> 8;
    end else begin
      rre = (PW+2)'(s_re_r);
      rim = (PW+2)'(s_im_r);
    end
    sat_re = 1'b0;
    sat_im = 1'b0;
    res_re = rre[DW-1:0];
    res_im = rim[DW-1:0];
    if (rre > (PW+2)'(32767)) begin
      sat_re = 1'b1;
      res_re = 16'h7fff;
    end else if (rre < -(PW+2)'(32768)) begin
      sat_re = 1'b1;
      res_re = 16'h8000;
    end
    if (rim > (PW+2)'(32767)) begin
      sat_im = 1'b1;
      res_im = 16'h7fff;
    end else if (rim < -(PW+2)'(32768)) begin
      sat_im = 1'b1;
      res_im = 16'h8000;
    end
    side_nxt.is_div = (kind2_r == KIND_DIV);
    side_nxt.dz     = (den == '0);
    side_nxt.neg_re = num_re[PW];
    side_nxt.neg_im = num_im[PW];
    side_nxt.re     = res_re;
    side_nxt.im     = res_im;
    side_nxt.status = (sat_re || sat_im) ? ST_SAT : ST_OK;
    n_re_nxt = RW'({mag_re, 9'b0}) + RW'(den);
    n_im_nxt = RW'({mag_im, 9'b0}) + RW'(den);
    d_nxt    = RW'({den, 1'b0});
  end

  assign fr_valid = v3_r;
  assign fr_side  = side3_r;
  assign fr_n_re  = n_re_r;
  assign fr_n_im  = n_im_r;
  assign fr_d     = d_r;

endmodule
`default_nettype wire

// ===== rtl/cau_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, two lanes.
`default_nettype none
module cau_divider
  import cau_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          dv_valid,
  input  wire cau_side_t     dv_side,
  input  wire logic [RW-1:0] dv_n_re,
  input  wire logic [RW-1:0] dv_n_im,
  input  wire logic [RW-1:0] dv_d,
  output logic               dq_valid,
  output cau_side_t          dq_side,
  output logic [QB-1:0]      dq_re,
  output logic [QB-1:0]      dq_im,
  output logic               dq_of_re,
  output logic               dq_of_im
);

  logic          v_r    [0:QB];
  cau_side_t     side_r [0:QB];
  logic [RW-1:0] r_re_r [0:QB];
  logic [RW-1:0] r_im_r [0:QB];
  logic [RW-1:0] d_r    [0:QB];
  logic [QB-1:0] q_re_r [0:QB];
  logic [QB-1:0] q_im_r [0:QB];
  logic          of_re_r[0:QB];
  logic          of_im_r[0:QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0]  <= dv_side;
      r_re_r[0]  <= dv_n_re;
      r_im_r[0]  <= dv_n_im;
      d_r[0]     <= dv_d;
      q_re_r[0]  <= '0;
      q_im_r[0]  <= '0;
      of_re_r[0] <= (dv_n_re >= (dv_d << QB));
      of_im_r[0] <= (dv_n_im >= (dv_d << QB));
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [RW-1:0] sh;
    logic          ge_re, ge_im;
    assign sh    = d_r[k-1] << (QB - k);
    assign ge_re = (r_re_r[k-1] >= sh);
    assign ge_im = (r_im_r[k-1] >= sh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k]  <= side_r[k-1];
        d_r[k]     <= d_r[k-1];
        of_re_r[k] <= of_re_r[k-1];
        of_im_r[k] <= of_im_r[k-1];
        r_re_r[k]  <= ge_re ? r_re_r[k-1] - sh : r_re_r[k-1];
        r_im_r[k]  <= ge_im ? r_im_r[k-1] - sh : r_im_r[k-1];
        q_re_r[k]  <= {q_re_r[k-1][QB-2:0], ge_re};
        q_im_r[k]  <= {q_im_r[k-1][QB-2:0], ge_im};
      end
    end
  end

  assign dq_valid = v_r[QB];
  assign dq_side  = side_r[QB];
  assign dq_re    = q_re_r[QB];
  assign dq_im    = q_im_r[QB];
  assign dq_of_re = of_re_r[QB];
  assign dq_of_im = of_im_r[QB];

endmodule
`default_nettype wire

// ===== rtl/complex_arith_unit_top.sv =====
// Top level of the complex arithmetic unit: pipeline control and result stage.
// Usage:
//   Input channel in_valid/in_ready carries in_kind (0 add, 1 subtract,
//   2 multiply, 3 divide) and two complex Q8.8 operands.
//   Result channel out_valid/out_ready carries out_res_re, out_res_im and
//   out_status (0 ok, 1 saturated, 2 divide by zero).
//   Latency is the same for every operation; it is set by the 17
//   quotient-bit stages of the divider plus three operand/product/sum
//   stages, one overflow check stage and the output register.
//   Throughput is one transaction per cycle: a new item enters every cycle
//   while out_ready is high.
//   When the receiver holds out_ready low with a result waiting, the whole
//   pipeline freezes and in_ready drops; nothing is lost or repeated.
//   Reset clears every valid bit; no result is pending afterwards.
`default_nettype none
module complex_arith_unit_top
  import cau_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_kind,
  input  wire logic signed [DW-1:0] in_a_re,
  input  wire logic signed [DW-1:0] in_a_im,
  input  wire logic signed [DW-1:0] in_b_re,
  input  wire logic signed [DW-1:0] in_b_im,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [DW-1:0]      out_res_re,
  output logic signed [DW-1:0]      out_res_im,
  output logic [1:0]                out_status
);

  logic          en;
  logic          fr_valid, dq_valid, dq_of_re, dq_of_im;
  cau_side_t     fr_side, dq_side;
  logic [RW-1:0] fr_n_re, fr_n_im, fr_d;
  logic [QB-1:0] dq_re, dq_im;

  logic          out_valid_r;
  logic [DW-1:0] re_r, im_r, re_nxt, im_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          sat_re, sat_im;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_a_re  (in_a_re),
    .in_a_im  (in_a_im),
    .in_b_re  (in_b_re),
    .in_b_im  (in_b_im),
    .fr_valid (fr_valid),
    .fr_side  (fr_side),
    .fr_n_re  (fr_n_re),
    .fr_n_im  (fr_n_im),
    .fr_d     (fr_d)
  );

  cau_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .dv_valid (fr_valid),
    .dv_side  (fr_side),
    .dv_n_re  (fr_n_re),
    .dv_n_im  (fr_n_im),
    .dv_d     (fr_d),
    .dq_valid (dq_valid),
    .dq_side  (dq_side),
    .dq_re    (dq_re),
    .dq_im    (dq_im),
    .dq_of_re (dq_of_re),
    .dq_of_im (dq_of_im)
  );

  always_comb begin
    sat_re = 1'b0;
    sat_im = 1'b0;
    re_nxt = dq_side.re;
    im_nxt = dq_side.im;
    st_nxt = dq_side.status;
    if (dq_side.is_div) begin
      if (dq_side.dz) begin
        re_nxt = '0;
        im_nxt = '0;
        st_nxt = ST_DZ;
      end else begin
        if (!dq_side.neg_re) begin
          sat_re = dq_of_re || (dq_re > QB'(32767));
          re_nxt = sat_re ? 16'h7fff : dq_re[DW-1:0];
        end else begin
          sat_re = dq_of_re || (dq_re > QB'(32768));
          re_nxt = sat_re ? 16'h8000 : DW'(-dq_re);
        end
        if (!dq_side.neg_im) begin
          sat_im = dq_of_im || (dq_im > QB'(32767));
          im_nxt = sat_im ? 16'h7fff : dq_im[DW-1:0];
        end else begin
          sat_im = dq_of_im || (dq_im > QB'(32768));
          im_nxt = sat_im ? 16'h8000 : DW'(-dq_im);
        end
        st_nxt = (sat_re || sat_im) ? ST_SAT : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_res_re = re_r;
  assign out_res_im = im_r;
  assign out_status = st_r;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && st_r == ST_DZ |-> re_r == '0 && im_r == '0)
    else $error("divide by zero result not zero");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> st_r == ST_OK || st_r == ST_SAT || st_r == ST_DZ)
    else $error("undefined status code");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && st_r == ST_SAT |->
      re_r == 16'h7fff || re_r == 16'h8000 || im_r == 16'h7fff || im_r == 16'h8000)
    else $error("saturation status without a saturated part");

endmodule
`default_nettype wire

// ===== tb/sv/cau_checker.sv =====
// Checker for the complex arithmetic unit: predicts results and compares them.
`timescale 1ns / 100ps
module cau_checker
  import cau_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [1:0]           in_kind,
  input  logic signed [DW-1:0] in_a_re,
  input  logic signed [DW-1:0] in_a_im,
  input  logic signed [DW-1:0] in_b_re,
  input  logic signed [DW-1:0] in_b_im,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [DW-1:0] out_res_re,
  input  logic signed [DW-1:0] out_res_im,
  input  logic [1:0]           out_status,
  output int                   fail_count,
  output int                   pending_count
);

  typedef struct {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic [1:0]           status;
  } cplx_result_t;

  cplx_result_t result_fifo[$];

  function automatic longint floor256(longint v);
    if (v >= 0) return v / 256;
    return -((-v + 255) / 256);
  endfunction

  function automatic longint quot_round(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag * 512 + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [DW-1:0] clamp16(longint v, inout logic sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'sh8000;
    end
    return v[DW-1:0];
  endfunction

  function automatic cplx_result_t compute_result(logic [1:0] k, longint ar, longint ai,
                                                  longint br, longint bi);
    cplx_result_t r;
    longint re;
    longint im;
    longint den;
    logic sat;
    re = 0;
    im = 0;
    sat = 1'b0;
    r.status = ST_OK;
    case (kind_t'(k))
      KIND_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      KIND_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      KIND_MUL: begin
        re = floor256(ar * br - ai * bi + 128);
        im = floor256(ar * bi + br * ai + 128);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) r.status = ST_DZ;
        else begin
          re = quot_round(ar * br + ai * bi, den);
          im = quot_round(ai * br - ar * bi, den);
        end
      end
    endcase
    r.re = clamp16(re, sat);
    r.im = clamp16(im, sat);
    if (r.status == ST_OK && sat) r.status = ST_SAT;
    return r;
  endfunction

  initial fail_count = 0;
  assign pending_count = result_fifo.size();

  always @(posedge clk) begin
    cplx_result_t e;
    if (rst_n) begin
      if (in_valid && in_ready)
        result_fifo.push_back(compute_result(in_kind, in_a_re, in_a_im, in_b_re, in_b_im));
      if (out_valid && out_ready) begin
        if (result_fifo.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result re=%0d im=%0d st=%0d",
                                         out_res_re, out_res_im, out_status);
        end else begin
          e = result_fifo.pop_front();
          if (e.re !== out_res_re || e.im !== out_res_im || e.status !== out_status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected re=%0d im=%0d st=%0d, got re=%0d im=%0d st=%0d",
                       e.re, e.im, e.status, out_res_re, out_res_im, out_status);
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the complex arithmetic unit: stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import cau_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [1:0] in_kind = KIND_ADD;
  logic signed [DW-1:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid;
  logic signed [DW-1:0] out_res_re, out_res_im;
  logic [1:0] out_status;
  int fail_count, pending_count;
  int cycle_count = 0;
  bit quiet = 1'b0;

  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT = 200000;

  always #5 clk = ~clk;

  complex_arith_unit_top uut (.*);

  cau_checker chk (.*);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int stall;
    out_ready = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 12);
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_op(logic [1:0] k, logic [15:0] ar, logic [15:0] ai,
                         logic [15:0] br, logic [15:0] bi);
    in_valid = 1'b1;
    in_kind = k;
    in_a_re = ar;
    in_a_im = ai;
    in_b_re = br;
    in_b_im = bi;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_part();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 1023)) - 512);
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] ext[4];
    int idle;
    ext = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    for (int k = 0; k < 4; k++) begin
      send_op(2'(k), 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
      send_op(2'(k), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_op(2'(k), 16'h0100, 16'hff00, 16'h0080, 16'h0001);
      send_op(2'(k), ext[k], 16'h0001, 16'h0000, 16'h0000);
      send_op(2'(k), 16'h0180, 16'h0040, 16'hff80, 16'h0080);
    end
    send_op(KIND_DIV, 16'h0001, 16'h0000, 16'h7fff, 16'h7fff);
    send_op(KIND_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i > RANDOM_ITEMS - 200) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) begin
        idle = $urandom_range(1, 12);
        repeat (idle) @(negedge clk);
      end
      in_valid = 1'b1;
      in_kind = 2'($urandom);
      in_a_re = pick_part();
      in_a_im = pick_part();
      in_b_re = ($urandom_range(0, 20) == 0) ? 16'h0000 : pick_part();
      in_b_im = ($urandom_range(0, 20) == 0) ? 16'h0000 : pick_part();
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
      in_valid = 1'b0;
    end
    while (pending_count != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_divider.sv
rtl/complex_arith_unit_top.sv
tb/sv/cau_checker.sv
tb/sv/tb_top.sv
